// ===== sv/tmsw_pkg.sv =====
// Shared constants, codes and types of the text mode screen writer.
// Used by tmsw_screen_ram, tmsw_cursor_unit and text_mode_screen_writer.
package tmsw_pkg;

  localparam int COLUMNS    = 80;
  localparam int USED_ROWS  = 24;
  localparam int CELL_COUNT = COLUMNS * USED_ROWS;
  localparam int COPY_COUNT = CELL_COUNT - COLUMNS;

  localparam int ADDR_W = 11;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int CODE_W = 9;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  localparam logic [ADDR_W-1:0] CELL_END  = ADDR_W'(CELL_COUNT);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY_LEN  = ADDR_W'(COPY_COUNT);
  localparam logic [ADDR_W-1:0] COL_STEP  = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [7:0]        BLANK_CHAR = 8'h20;

  localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'd10;
  localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'd256;
  localparam logic [CODE_W-1:0] CODE_LEFT      = 9'd228;
  localparam logic [CODE_W-1:0] CODE_RIGHT     = 9'd229;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Outcome of one put code applied to the cursor.
  typedef struct packed {
    logic [ADDR_W-1:0] cursor;
    logic [COL_W-1:0]  col;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              scroll;
  } step_t;

endpackage

// ===== sv/tmsw_screen_ram.sv =====
// Screen cell store: one write port and one registered read port.
// Depends on tmsw_pkg for depth and widths.
module tmsw_screen_ram (
  input  logic                           clk,
  input  logic                           we,
  input  logic [tmsw_pkg::ADDR_W-1:0]    waddr,
  input  logic [tmsw_pkg::CELL_W-1:0]    wdata,
  input  logic                           re,
  input  logic [tmsw_pkg::ADDR_W-1:0]    raddr,
  output logic [tmsw_pkg::CELL_W-1:0]    rdata
);

  logic [tmsw_pkg::CELL_W-1:0] mem [tmsw_pkg::CELL_COUNT];
  logic [tmsw_pkg::CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/tmsw_cursor_unit.sv =====
// Cursor arithmetic for one put code: new cursor, column, cell write and scroll.
// Depends on tmsw_pkg for codes, constants and step_t.
module tmsw_cursor_unit (
  input  logic [tmsw_pkg::ADDR_W-1:0] cursor,
  input  logic [tmsw_pkg::COL_W-1:0]  col,
  input  logic [tmsw_pkg::CODE_W-1:0] code,
  input  logic [tmsw_pkg::ATTR_W-1:0] attr,
  output tmsw_pkg::step_t             step
);

  logic [tmsw_pkg::ADDR_W-1:0] nc;
  logic [tmsw_pkg::COL_W-1:0]  ncol;
  logic [tmsw_pkg::COL_W-1:0]  col_dec;
  logic [tmsw_pkg::COL_W-1:0]  col_inc;
  logic                        at_first;
  logic                        at_last;

  assign at_first = (cursor == '0);
  assign at_last  = (cursor == tmsw_pkg::CELL_LAST);
  assign col_dec  = (col == '0) ? tmsw_pkg::COL_LAST : col - 1'b1;
  assign col_inc  = (col == tmsw_pkg::COL_LAST) ? '0 : col + 1'b1;

  always_comb begin
    nc         = cursor;
    ncol       = col;
    step.we    = 1'b0;
    step.waddr = cursor;
    step.wdata = {attr, code[7:0]};
    if (code == tmsw_pkg::CODE_NEWLINE) begin
      nc   = cursor + (tmsw_pkg::COL_STEP - tmsw_pkg::ADDR_W'(col));
      ncol = '0;
    end else if (code == tmsw_pkg::CODE_BACKSPACE) begin
      if (!at_first) begin
        nc   = cursor - 1'b1;
        ncol = col_dec;
      end
      step.we    = 1'b1;
      step.waddr = nc;
      step.wdata = {attr, tmsw_pkg::BLANK_CHAR};
    end else if (code == tmsw_pkg::CODE_LEFT) begin
      if (!at_first) begin
        nc   = cursor - 1'b1;
        ncol = col_dec;
      end
    end else if (code == tmsw_pkg::CODE_RIGHT) begin
      if (!at_last) begin
        nc   = cursor + 1'b1;
        ncol = col_inc;
      end
    end else begin
      step.we = 1'b1;
      nc      = cursor + 1'b1;
      ncol    = col_inc;
    end

    // The cursor can only leave the screen by landing exactly one past it.
    step.scroll = (nc == tmsw_pkg::CELL_END);
    step.cursor = step.scroll ? tmsw_pkg::COPY_LEN : nc;
    step.col    = step.scroll ? '0 : ncol;
  end

endmodule

// ===== sv/text_mode_screen_writer.sv =====
// Text mode screen writer: cursor handling over a store of attribute/character cells.
// Flow: a plain put or a read passes through ST_EMIT, which hands its result beat to the output
// register once the output is free; no new input beat is taken until then. A scroll first runs
// a row copy of COPY_COUNT cells and a row clear of COLUMNS cells, paced by the single write port.
// Reset (synchronous, rst_n low) clears the cursor, sets the attribute to 7 and then
// sweeps all CELL_COUNT (1920) cells of the store to zero with in_tready low.
module text_mode_screen_writer (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: text attribute byte.
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [8:0] code, [19:9] cell_address, [23:20] zero
  input  logic        in_tuser,   // [0] op
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [10:0] cursor, [26:11] cell_data, [27] scrolled
);

  // One-hot sequencer. WIPE clears the store after reset, COPY moves every row up
  // by one, CLEAR zeroes the last row, EMIT hands the result to the output register.
  typedef enum logic [4:0] {
    ST_WIPE  = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_COPY  = 5'b00100,
    ST_CLEAR = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [tmsw_pkg::ATTR_W-1:0] attr_r;
  logic [tmsw_pkg::ADDR_W-1:0] cursor_r, cursor_nxt;
  logic [tmsw_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [tmsw_pkg::ADDR_W-1:0] idx_r, idx_nxt;
  logic [tmsw_pkg::ADDR_W-1:0] dst_r;
  logic                        pend_r, pend_nxt;
  logic                        res_rd_r, res_rd_nxt;
  logic                        res_scr_r, res_scr_nxt;
  logic                        out_valid_r;
  logic [31:0]                 out_data_r;

  logic                        accept;
  logic                        in_op;
  logic [tmsw_pkg::CODE_W-1:0] in_code;
  logic [tmsw_pkg::ADDR_W-1:0] in_addr;
  logic                        addr_ok;
  logic                        out_free;
  logic                        idx_last;
  logic [tmsw_pkg::ADDR_W-1:0] idx_inc;
  logic [tmsw_pkg::ADDR_W-1:0] idx_src;

  tmsw_pkg::step_t             step;

  logic                        ram_we;
  logic [tmsw_pkg::ADDR_W-1:0] ram_waddr;
  logic [tmsw_pkg::CELL_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [tmsw_pkg::ADDR_W-1:0] ram_raddr;
  logic [tmsw_pkg::CELL_W-1:0] ram_rdata;

  assign in_op    = in_tuser;
  assign in_code  = in_tdata[8:0];
  assign in_addr  = in_tdata[19:9];
  assign in_tready = (state_r == ST_IDLE);
  assign accept   = in_tvalid && in_tready;
  assign addr_ok  = (in_addr < tmsw_pkg::CELL_END);
  assign out_free = !out_valid_r || out_tready;

  // The shared address unit: one incrementer on idx_r serves the reset sweep, the row copy and
  // the row clear; the row offset on idx_r serves the row copy.
  assign idx_inc  = idx_r + 1'b1;
  assign idx_src  = idx_r + tmsw_pkg::COL_STEP;
  assign idx_last = (idx_r == tmsw_pkg::CELL_LAST);

  tmsw_cursor_unit u_cursor (
    .cursor (cursor_r),
    .col    (col_r),
    .code   (in_code),
    .attr   (attr_r),
    .step   (step)
  );

  tmsw_screen_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Store port steering. During the copy the read of a source cell is issued in the cycle
  // before its write to the same column one row up.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = idx_src;
    unique case (state_r)
      ST_WIPE, ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_waddr = step.waddr;
        ram_wdata = step.wdata;
        ram_we    = accept && (in_op == tmsw_pkg::OP_PUT) && step.we;
        ram_raddr = in_addr;
        ram_re    = accept && (in_op == tmsw_pkg::OP_READ) && addr_ok;
      end
      ST_COPY: begin
        ram_we    = pend_r;
        ram_waddr = dst_r;
        ram_wdata = ram_rdata;
        ram_re    = (idx_r != tmsw_pkg::COPY_LEN);
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    cursor_nxt  = cursor_r;
    col_nxt     = col_r;
    idx_nxt     = idx_r;
    pend_nxt    = 1'b0;
    res_rd_nxt  = res_rd_r;
    res_scr_nxt = res_scr_r;
    unique case (state_r)
      ST_WIPE: begin
        idx_nxt = idx_inc;
        if (idx_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_op == tmsw_pkg::OP_READ) begin
            res_rd_nxt  = addr_ok;
            res_scr_nxt = 1'b0;
            state_nxt   = ST_EMIT;
          end else begin
            res_rd_nxt  = 1'b0;
            res_scr_nxt = step.scroll;
            cursor_nxt  = step.cursor;
            col_nxt     = step.col;
            idx_nxt     = '0;
            state_nxt   = step.scroll ? ST_COPY : ST_EMIT;
          end
        end
      end
      ST_COPY: begin
        pend_nxt = (idx_r != tmsw_pkg::COPY_LEN);
        if (idx_r == tmsw_pkg::COPY_LEN) begin
          state_nxt = ST_CLEAR;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      ST_CLEAR: begin
        idx_nxt = idx_inc;
        if (idx_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_WIPE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WIPE;
      attr_r      <= tmsw_pkg::ATTR_RESET;
      cursor_r    <= '0;
      col_r       <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      res_rd_r    <= 1'b0;
      res_scr_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cursor_r  <= cursor_nxt;
      col_r     <= col_nxt;
      idx_r     <= idx_nxt;
      pend_r    <= pend_nxt;
      res_rd_r  <= res_rd_nxt;
      res_scr_r <= res_scr_nxt;
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
      if ((state_r == ST_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    dst_r <= idx_r;
    if ((state_r == ST_EMIT) && out_free) begin
      out_data_r <= {4'b0000, res_scr_r, (res_rd_r ? ram_rdata : 16'h0000), cursor_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The cursor stays on screen and its column stays inside a row.
  a_cursor_col : assert property (@(posedge clk) disable iff (!rst_n)
    (cursor_r < tmsw_pkg::CELL_END) && (col_r <= tmsw_pkg::COL_LAST))
    else $error("cursor or column out of range");

  // A scrolled result always leaves the cursor at the start of the last row.
  a_scroll_cursor : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[27]) |-> (out_tdata[10:0] == tmsw_pkg::COPY_LEN))
    else $error("scroll result with wrong cursor");

  // A new result beat only follows the emit step.
  a_emit_only : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_EMIT))
    else $error("result beat without emit");

  // Copy writes always land below COPY_LEN, in the rows that receive the moved cells.
  a_copy_write : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY && pend_r) |-> (dst_r < tmsw_pkg::COPY_LEN))
    else $error("copy write outside the moved rows");

endmodule
